@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/lav_pkg.sv @@
package lav_pkg;

    localparam int DATA_W    = 32;
    localparam int VEC_W     = 3 * DATA_W;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int CROSS_W   = 2 * DATA_W + 1;
    localparam int MAG_W     = 30;
    localparam int LEN_W     = 31;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_UP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 2'd2;

    localparam logic [DATA_W-1:0] UP_X_RST = 32'h0000_0000;
    localparam logic [DATA_W-1:0] UP_Y_RST = 32'h0001_0000;
    localparam logic [DATA_W-1:0] UP_Z_RST = 32'h0000_0000;

    typedef logic [2:0][DATA_W-1:0] t_vec3;

    typedef struct packed {
        logic signed [DATA_W-1:0] right_x;
        logic signed [DATA_W-1:0] right_y;
        logic signed [DATA_W-1:0] right_z;
        logic signed [DATA_W-1:0] upward_x;
        logic signed [DATA_W-1:0] upward_y;
        logic signed [DATA_W-1:0] upward_z;
        logic signed [DATA_W-1:0] back_x;
        logic signed [DATA_W-1:0] back_y;
        logic signed [DATA_W-1:0] back_z;
        logic signed [DATA_W-1:0] shift_x;
        logic signed [DATA_W-1:0] shift_y;
        logic signed [DATA_W-1:0] shift_z;
    } t_result;

endpackage

@@ rtl/lav_in_if.sv @@
interface lav_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [lav_pkg::DATA_W-1:0]  eye_x;
    logic signed [lav_pkg::DATA_W-1:0]  eye_y;
    logic signed [lav_pkg::DATA_W-1:0]  eye_z;
    logic signed [lav_pkg::DATA_W-1:0]  target_x;
    logic signed [lav_pkg::DATA_W-1:0]  target_y;
    logic signed [lav_pkg::DATA_W-1:0]  target_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
        output ready
    );
endinterface

@@ rtl/lav_out_if.sv @@
interface lav_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lav_pkg::DATA_W-1:0]  right_x;
    logic signed [lav_pkg::DATA_W-1:0]  right_y;
    logic signed [lav_pkg::DATA_W-1:0]  right_z;
    logic signed [lav_pkg::DATA_W-1:0]  upward_x;
    logic signed [lav_pkg::DATA_W-1:0]  upward_y;
    logic signed [lav_pkg::DATA_W-1:0]  upward_z;
    logic signed [lav_pkg::DATA_W-1:0]  back_x;
    logic signed [lav_pkg::DATA_W-1:0]  back_y;
    logic signed [lav_pkg::DATA_W-1:0]  back_z;
    logic signed [lav_pkg::DATA_W-1:0]  shift_x;
    logic signed [lav_pkg::DATA_W-1:0]  shift_y;
    logic signed [lav_pkg::DATA_W-1:0]  shift_z;

    modport source (
        output valid, right_x, right_y, right_z, upward_x, upward_y, upward_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, right_x, right_y, right_z, upward_x, upward_y, upward_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

@@ rtl/lav_norm.sv @@
module lav_norm #(
    parameter int W  = lav_pkg::DIFF_W,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [2:0][W-1:0]   i_vec,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output lav_pkg::t_vec3      o_vec,
    output logic [SW-1:0]       o_side
);
    localparam int NSH  = $clog2(W);
    localparam int MW   = lav_pkg::MAG_W;
    localparam int QW   = lav_pkg::LEN_W;
    localparam int SQW  = 2 * QW;
    localparam int RW   = QW + 2;
    localparam int NUMW = MW + QW;
    localparam int CW   = SW + 4;
    localparam int DW   = lav_pkg::DATA_W;

    // ctl word: side band on top, sign bits [3:1], zero-length flag [0]

    // magnitude
    logic               r_a_valid;
    logic [2:0][W-1:0]  r_a_mag;
    logic [2:0]         r_a_neg;
    logic [SW-1:0]      r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_a_neg[k] <= i_vec[k][W-1];
                r_a_mag[k] <= i_vec[k][W-1] ? (~i_vec[k] + W'(1)) : i_vec[k];
            end
            r_a_side <= i_side;
        end
    end

    // largest magnitude, then leading-zero shift one power of two per stage
    logic               r_l_valid [0:NSH];
    logic [2:0][W-1:0]  r_l_mag   [0:NSH];
    logic [W-1:0]       r_l_big   [0:NSH];
    logic [CW-1:0]      r_l_ctl   [0:NSH];
    logic [W-1:0]       n_big;

    always_comb begin
        n_big = r_a_mag[0];
        if (r_a_mag[1] > n_big) begin
            n_big = r_a_mag[1];
        end
        if (r_a_mag[2] > n_big) begin
            n_big = r_a_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid[0] <= 1'b0;
        end else if (i_adv) begin
            r_l_valid[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l_mag[0] <= r_a_mag;
            r_l_big[0] <= n_big;
            r_l_ctl[0] <= {r_a_side, r_a_neg, (n_big == '0)};
        end
    end

    for (genvar k = 0; k < NSH; k++) begin : g_lz
        localparam int AMT = 1 << (NSH - 1 - k);
        logic hit;
        assign hit = (r_l_big[k][W-1 -: AMT] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_l_valid[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_l_valid[k+1] <= r_l_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_l_ctl[k+1] <= r_l_ctl[k];
                if (hit) begin
                    r_l_big[k+1] <= r_l_big[k] << AMT;
                    for (int j = 0; j < 3; j++) begin
                        r_l_mag[k+1][j] <= r_l_mag[k][j] << AMT;
                    end
                end else begin
                    r_l_big[k+1] <= r_l_big[k];
                    r_l_mag[k+1] <= r_l_mag[k];
                end
            end
        end
    end

    // squares of the top bits
    logic                   r_s_valid;
    logic [2:0][MW-1:0]     r_s_t;
    logic [2:0][2*MW-1:0]   r_s_sq;
    logic [CW-1:0]          r_s_ctl;
    logic [2:0][MW-1:0]     n_t;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_t[j] = r_l_mag[NSH][j][W-1 -: MW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_adv) begin
            r_s_valid <= r_l_valid[NSH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < 3; j++) begin
                r_s_sq[j] <= n_t[j] * n_t[j];
            end
            r_s_t   <= n_t;
            r_s_ctl <= r_l_ctl[NSH];
        end
    end

    // square root, one result bit per stage
    logic               r_q_valid [0:QW];
    logic [SQW-1:0]     r_q_n     [0:QW];
    logic [RW-1:0]      r_q_rem   [0:QW];
    logic [QW-1:0]      r_q_root  [0:QW];
    logic [2:0][MW-1:0] r_q_t     [0:QW];
    logic [CW-1:0]      r_q_ctl   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid[0] <= 1'b0;
        end else if (i_adv) begin
            r_q_valid[0] <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_q_n[0]    <= SQW'(r_s_sq[0]) + SQW'(r_s_sq[1]) + SQW'(r_s_sq[2]);
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
            r_q_t[0]    <= r_s_t;
            r_q_ctl[0]  <= r_s_ctl;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_sq
        localparam int P = SQW - 2 - 2 * j;
        logic [RW+1:0] r2;
        logic [RW+1:0] trial;
        logic          ge;

        assign r2    = {r_q_rem[j], r_q_n[j][P+1:P]};
        assign trial = (RW + 2)'({r_q_root[j], 2'b01});
        assign ge    = (r2 >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_valid[j+1] <= 1'b0;
            end else if (i_adv) begin
                r_q_valid[j+1] <= r_q_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q_rem[j+1]  <= ge ? RW'(r2 - trial) : RW'(r2);
                r_q_root[j+1] <= {r_q_root[j][QW-2:0], ge};
                r_q_n[j+1]    <= r_q_n[j];
                r_q_t[j+1]    <= r_q_t[j];
                r_q_ctl[j+1]  <= r_q_ctl[j];
            end
        end
    end

    // rounded quotient mag * 2^30 / length, one bit per stage
    logic                   r_d_valid [0:QW];
    logic [2:0][QW-1:0]     r_d_rem   [0:QW];
    logic [2:0][QW-1:0]     r_d_low   [0:QW];
    logic [2:0][QW-1:0]     r_d_quo   [0:QW];
    logic [QW-1:0]          r_d_len   [0:QW];
    logic [CW-1:0]          r_d_ctl   [0:QW];
    logic [2:0][NUMW-1:0]   n_num;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = NUMW'({r_q_t[QW][k], MW'(0)}) + NUMW'(r_q_root[QW] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else if (i_adv) begin
            r_d_valid[0] <= r_q_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_d_rem[0][k] <= QW'(n_num[k][NUMW-1:QW]);
                r_d_low[0][k] <= n_num[k][QW-1:0];
            end
            r_d_quo[0] <= '0;
            r_d_len[0] <= r_q_root[QW];
            r_d_ctl[0] <= r_q_ctl[QW];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_dv
        logic [2:0][QW:0] r2;
        logic [2:0]       ge;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                r2[k] = {r_d_rem[j][k], r_d_low[j][k][QW-1-j]};
                ge[k] = (r2[k] >= {1'b0, r_d_len[j]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[j+1] <= 1'b0;
            end else if (i_adv) begin
                r_d_valid[j+1] <= r_d_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                for (int k = 0; k < 3; k++) begin
                    r_d_rem[j+1][k] <= ge[k] ? QW'(r2[k] - {1'b0, r_d_len[j]}) : QW'(r2[k]);
                    r_d_quo[j+1][k] <= {r_d_quo[j][k][QW-2:0], ge[k]};
                end
                r_d_low[j+1] <= r_d_low[j];
                r_d_len[j+1] <= r_d_len[j];
                r_d_ctl[j+1] <= r_d_ctl[j];
            end
        end
    end

    // apply sign, force zero for a zero-length vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= r_d_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                if (r_d_ctl[QW][0]) begin
                    o_vec[k] <= '0;
                end else if (r_d_ctl[QW][k+1]) begin
                    o_vec[k] <= ~DW'(r_d_quo[QW][k]) + DW'(1);
                end else begin
                    o_vec[k] <= DW'(r_d_quo[QW][k]);
                end
            end
            o_side <= r_d_ctl[QW][CW-1:4];
        end
    end

endmodule

@@ rtl/lav_cross.sv @@
module lav_cross #(
    parameter int SW = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  lav_pkg::t_vec3                      i_a,
    input  lav_pkg::t_vec3                      i_b,
    input  logic [SW-1:0]                       i_side,
    output logic                                o_valid,
    output logic [2:0][lav_pkg::CROSS_W-1:0]    o_vec,
    output logic [SW-1:0]                       o_side
);
    localparam int PW = lav_pkg::PROD_W;
    localparam int XW = lav_pkg::CROSS_W;

    logic                   r_p_valid;
    logic signed [PW-1:0]   r_p [0:5];
    logic [SW-1:0]          r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_adv) begin
            r_p_valid <= i_valid;
            o_valid   <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p[0]   <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1]   <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2]   <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3]   <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4]   <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5]   <= $signed(i_a[1]) * $signed(i_b[0]);
            r_p_side <= i_side;
            o_vec[0] <= XW'(r_p[0]) - XW'(r_p[1]);
            o_vec[1] <= XW'(r_p[2]) - XW'(r_p[3]);
            o_vec[2] <= XW'(r_p[4]) - XW'(r_p[5]);
            o_side   <= r_p_side;
        end
    end

endmodule

@@ rtl/lav_shift.sv @@
module lav_shift (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  lav_pkg::t_vec3      i_x,
    input  lav_pkg::t_vec3      i_y,
    input  lav_pkg::t_vec3      i_z,
    input  lav_pkg::t_vec3      i_eye,
    output logic                o_valid,
    output lav_pkg::t_result    o_res
);
    localparam int DW  = lav_pkg::DATA_W;
    localparam int PW  = lav_pkg::PROD_W;
    localparam int SMW = PW + 2;
    localparam int NGW = SMW + 1;
    localparam int FR  = lav_pkg::MAG_W;
    localparam int RSW = NGW - FR;

    logic                   r_p_valid;
    logic signed [PW-1:0]   r_p [0:8];
    lav_pkg::t_vec3         r_p_ax [0:2];
    logic                   r_s_valid;
    logic signed [SMW-1:0]  r_s [0:2];
    lav_pkg::t_vec3         r_s_ax [0:2];
    lav_pkg::t_vec3         n_ax [0:2];
    logic signed [NGW-1:0]  n_ng [0:2];
    logic signed [RSW-1:0]  n_rd [0:2];
    logic [2:0][DW-1:0]     n_sat;

    assign n_ax[0] = i_x;
    assign n_ax[1] = i_y;
    assign n_ax[2] = i_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_adv) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
            o_valid   <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[3*a+c] <= $signed(n_ax[a][c]) * $signed(i_eye[c]);
                end
                r_p_ax[a] <= n_ax[a];
                r_s[a]    <= SMW'(r_p[3*a]) + SMW'(r_p[3*a+1]) + SMW'(r_p[3*a+2]);
                r_s_ax[a] <= r_p_ax[a];
            end
        end
    end

    // negate, round half up, drop the fraction and saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_ng[a] = -NGW'(r_s[a]) + (NGW'(1) <<< (FR - 1));
            n_rd[a] = RSW'(n_ng[a] >>> FR);
            if (n_rd[a][RSW-1:DW-1] == '0 || n_rd[a][RSW-1:DW-1] == '1) begin
                n_sat[a] = n_rd[a][DW-1:0];
            end else if (n_rd[a][RSW-1]) begin
                n_sat[a] = {1'b1, {(DW-1){1'b0}}};
            end else begin
                n_sat[a] = {1'b0, {(DW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_res.right_x  <= r_s_ax[0][0];
            o_res.right_y  <= r_s_ax[0][1];
            o_res.right_z  <= r_s_ax[0][2];
            o_res.upward_x <= r_s_ax[1][0];
            o_res.upward_y <= r_s_ax[1][1];
            o_res.upward_z <= r_s_ax[1][2];
            o_res.back_x   <= r_s_ax[2][0];
            o_res.back_y   <= r_s_ax[2][1];
            o_res.back_z   <= r_s_ax[2][2];
            o_res.shift_x  <= n_sat[0];
            o_res.shift_y  <= n_sat[1];
            o_res.shift_z  <= n_sat[2];
        end
    end

endmodule

@@ rtl/look_at_view_matrix.sv @@
// Look-at view basis in fixed point. Each request carries an eye and a target point
// (signed Q16.16); with the up vector held in the three configuration registers it yields
// the right, upward and back axes in Q2.30 and the three saturated Q16.16 translations.
// One request is taken every clock unless the output stalls; each of the three normalizers
// holds a chain of 31 square-root stages and 31 divide stages producing one bit per stage.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated. Write the
// up vector only while no request is in flight.
`include "assert_macros.svh"

module look_at_view_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lav_in_if.sink                              i_in,
    lav_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [lav_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lav_pkg::DATA_W-1:0]          i_cfg_data
);
    localparam int DW = lav_pkg::DATA_W;
    localparam int VW = lav_pkg::VEC_W;
    localparam int XW = lav_pkg::CROSS_W;
    localparam int FW = lav_pkg::DIFF_W;

    logic [DW-1:0]          r_up_x;
    logic [DW-1:0]          r_up_y;
    logic [DW-1:0]          r_up_z;
    logic                   w_adv;
    logic                   w_res_valid;
    lav_pkg::t_result       w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_x <= lav_pkg::UP_X_RST;
            r_up_y <= lav_pkg::UP_Y_RST;
            r_up_z <= lav_pkg::UP_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lav_pkg::REG_UP_X: r_up_x <= i_cfg_data;
                lav_pkg::REG_UP_Y: r_up_y <= i_cfg_data;
                lav_pkg::REG_UP_Z: r_up_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance everything unless the result register is full and held
    assign w_adv      = !w_res_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // eye minus target
    logic                   r_d_valid;
    logic [2:0][FW-1:0]     r_d;
    lav_pkg::t_vec3         r_d_eye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_adv) begin
            r_d_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d[0]  <= FW'(i_in.eye_x) - FW'(i_in.target_x);
            r_d[1]  <= FW'(i_in.eye_y) - FW'(i_in.target_y);
            r_d[2]  <= FW'(i_in.eye_z) - FW'(i_in.target_z);
            r_d_eye <= {i_in.eye_z, i_in.eye_y, i_in.eye_x};
        end
    end

    // back axis
    logic                   w_z_valid;
    lav_pkg::t_vec3         w_z;
    lav_pkg::t_vec3         w_z_eye;

    lav_norm #(.W(FW), .SW(VW)) u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_d_valid),
        .i_vec   (r_d),
        .i_side  (r_d_eye),
        .o_valid (w_z_valid),
        .o_vec   (w_z),
        .o_side  (w_z_eye)
    );

    // up cross back
    logic                   w_xr_valid;
    logic [2:0][XW-1:0]     w_xr;
    logic [2*VW-1:0]        w_xr_side;

    lav_cross #(.SW(2 * VW)) u_cross_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_z_valid),
        .i_a     ({r_up_z, r_up_y, r_up_x}),
        .i_b     (w_z),
        .i_side  ({w_z_eye, w_z}),
        .o_valid (w_xr_valid),
        .o_vec   (w_xr),
        .o_side  (w_xr_side)
    );

    // right axis
    logic                   w_x_valid;
    lav_pkg::t_vec3         w_x;
    logic [2*VW-1:0]        w_x_side;

    lav_norm #(.W(XW), .SW(2 * VW)) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_xr_valid),
        .i_vec   (w_xr),
        .i_side  (w_xr_side),
        .o_valid (w_x_valid),
        .o_vec   (w_x),
        .o_side  (w_x_side)
    );

    // back cross right
    logic                   w_yr_valid;
    logic [2:0][XW-1:0]     w_yr;
    logic [3*VW-1:0]        w_yr_side;

    lav_cross #(.SW(3 * VW)) u_cross_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_x_valid),
        .i_a     (w_x_side[VW-1:0]),
        .i_b     (w_x),
        .i_side  ({w_x_side, w_x}),
        .o_valid (w_yr_valid),
        .o_vec   (w_yr),
        .o_side  (w_yr_side)
    );

    // upward axis
    logic                   w_y_valid;
    lav_pkg::t_vec3         w_y;
    logic [3*VW-1:0]        w_y_side;

    lav_norm #(.W(XW), .SW(3 * VW)) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_yr_valid),
        .i_vec   (w_yr),
        .i_side  (w_yr_side),
        .o_valid (w_y_valid),
        .o_vec   (w_y),
        .o_side  (w_y_side)
    );

    // side band layout here: eye on top, then back axis, then right axis
    lav_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_y_valid),
        .i_x     (w_y_side[VW-1:0]),
        .i_y     (w_y),
        .i_z     (w_y_side[2*VW-1:VW]),
        .i_eye   (w_y_side[3*VW-1:2*VW]),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    assign o_out.valid    = w_res_valid;
    assign o_out.right_x  = w_res.right_x;
    assign o_out.right_y  = w_res.right_y;
    assign o_out.right_z  = w_res.right_z;
    assign o_out.upward_x = w_res.upward_x;
    assign o_out.upward_y = w_res.upward_y;
    assign o_out.upward_z = w_res.upward_z;
    assign o_out.back_x   = w_res.back_x;
    assign o_out.back_y   = w_res.back_y;
    assign o_out.back_z   = w_res.back_z;
    assign o_out.shift_x  = w_res.shift_x;
    assign o_out.shift_y  = w_res.shift_y;
    assign o_out.shift_z  = w_res.shift_z;

    logic w_unit_ok;
    logic w_right_zero;
    logic w_upward_zero;
    logic w_back_zero;

    always_comb begin
        w_unit_ok = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if ($signed(w_res[(11-k)*DW +: DW]) > 32'sd1073741824 ||
                $signed(w_res[(11-k)*DW +: DW]) < -32'sd1073741824) begin
                w_unit_ok = 1'b0;
            end
        end
    end

    assign w_right_zero  = (w_res.right_x == '0) && (w_res.right_y == '0) &&
                           (w_res.right_z == '0);
    assign w_upward_zero = (w_res.upward_x == '0) && (w_res.upward_y == '0) &&
                           (w_res.upward_z == '0);
    assign w_back_zero   = (w_res.back_x == '0) && (w_res.back_y == '0) &&
                           (w_res.back_z == '0);

    `ASSERT_IMPLY(a_unit_range, i_clk, i_rst_n, w_res_valid, w_unit_ok, "axis component beyond one")
    `ASSERT_IMPLY(a_right_zero, i_clk, i_rst_n, w_res_valid && w_right_zero, w_upward_zero && (w_res.shift_x == '0) && (w_res.shift_y == '0), "degenerate right axis not propagated")
    `ASSERT_IMPLY(a_back_zero, i_clk, i_rst_n, w_res_valid && w_back_zero, w_right_zero && (w_res.shift_z == '0), "degenerate back axis not propagated")

endmodule

@@ dv/lav_view_checker.sv @@
module lav_view_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lav_in_if                             i_in_mon,
    lav_out_if                            i_out_mon,
    input  logic                          i_cfg_we,
    input  logic [lav_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lav_pkg::DATA_W-1:0]    i_cfg_data,
    output int                            o_fail_cnt,
    output int                            o_pending
);
    import lav_pkg::*;

    logic signed [DATA_W-1:0] up_vec [3];
    t_result                  view_q [$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale so the largest magnitude sits in [2^29, 2^30), then divide by the length.
    function automatic void unit_vec(input longint v [3], output longint r [3]);
        longint unsigned m [3];
        longint unsigned big, sum, len, q;
        int              nbits;
        for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        if (big == 0) begin
            r[0] = 0; r[1] = 0; r[2] = 0;
            return;
        end
        nbits = 0;
        while (nbits < 64 && (big >> nbits) != 0) nbits++;
        for (int i = 0; i < 3; i++) begin
            if (nbits > 30) m[i] = m[i] >> (nbits - 30);
            else if (nbits < 30) m[i] = m[i] << (30 - nbits);
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q    = (m[i] * 64'd1073741824 + (len >> 1)) / len;
            r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_prod(input longint a [3], input longint b [3],
                                       output longint r [3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Negative dot in Q18.46, round halves up to Q16.16, saturate.
    function automatic logic [DATA_W-1:0] translation(input longint ax [3],
                                                      input longint eye [3]);
        longint s;
        s = -(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]);
        s = (s + (64'sd1 <<< 29)) >>> 30;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[DATA_W-1:0];
    endfunction

    function automatic t_result build_view(input longint eye [3], input longint tgt [3]);
        longint  dir [3], upv [3], back [3], rraw [3], right [3], uraw [3], upw [3];
        t_result res;
        for (int i = 0; i < 3; i++) begin
            dir[i] = eye[i] - tgt[i];
            upv[i] = up_vec[i];
        end
        unit_vec(dir, back);
        cross_prod(upv, back, rraw);
        unit_vec(rraw, right);
        cross_prod(back, right, uraw);
        unit_vec(uraw, upw);
        res.right_x  = right[0][DATA_W-1:0];
        res.right_y  = right[1][DATA_W-1:0];
        res.right_z  = right[2][DATA_W-1:0];
        res.upward_x = upw[0][DATA_W-1:0];
        res.upward_y = upw[1][DATA_W-1:0];
        res.upward_z = upw[2][DATA_W-1:0];
        res.back_x   = back[0][DATA_W-1:0];
        res.back_y   = back[1][DATA_W-1:0];
        res.back_z   = back[2][DATA_W-1:0];
        res.shift_x  = translation(right, eye);
        res.shift_y  = translation(upw, eye);
        res.shift_z  = translation(back, eye);
        return res;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            o_fail_cnt++;
        end
    endfunction

    assign o_pending = view_q.size();

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin
        longint  eye [3], tgt [3];
        t_result exp_r;
        if (!i_rst_n) begin
            up_vec[0] = UP_X_RST;
            up_vec[1] = UP_Y_RST;
            up_vec[2] = UP_Z_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_UP_X: up_vec[0] = i_cfg_data;
                    REG_UP_Y: up_vec[1] = i_cfg_data;
                    REG_UP_Z: up_vec[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                eye[0] = i_in_mon.eye_x;
                eye[1] = i_in_mon.eye_y;
                eye[2] = i_in_mon.eye_z;
                tgt[0] = i_in_mon.target_x;
                tgt[1] = i_in_mon.target_y;
                tgt[2] = i_in_mon.target_z;
                view_q.push_back(build_view(eye, tgt));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (view_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_cnt++;
                end else begin
                    exp_r = view_q.pop_front();
                    check_field("right_x",  exp_r.right_x,  i_out_mon.right_x);
                    check_field("right_y",  exp_r.right_y,  i_out_mon.right_y);
                    check_field("right_z",  exp_r.right_z,  i_out_mon.right_z);
                    check_field("upward_x", exp_r.upward_x, i_out_mon.upward_x);
                    check_field("upward_y", exp_r.upward_y, i_out_mon.upward_y);
                    check_field("upward_z", exp_r.upward_z, i_out_mon.upward_z);
                    check_field("back_x",   exp_r.back_x,   i_out_mon.back_x);
                    check_field("back_y",   exp_r.back_y,   i_out_mon.back_y);
                    check_field("back_z",   exp_r.back_z,   i_out_mon.back_z);
                    check_field("shift_x",  exp_r.shift_x,  i_out_mon.shift_x);
                    check_field("shift_y",  exp_r.shift_y,  i_out_mon.shift_y);
                    check_field("shift_z",  exp_r.shift_z,  i_out_mon.shift_z);
                end
            end
        end
    end
endmodule

@@ dv/tb_look_at_view_matrix.sv @@
module tb_look_at_view_matrix;
    import lav_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LEN = 700;
    localparam int DRAIN_LEN = 260;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;
    int                   fail_cnt;
    int                   pending;
    int                   idle_in;
    int                   idle_out;
    int                   stall_req;
    int                   stall_seen;
    int                   quiet_cycles;

    lav_in_if  in_if ();
    lav_out_if out_if ();

    look_at_view_matrix DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    lav_view_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_if),
        .i_out_mon  (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random backpressure, plus one long hold when asked.
    initial begin
        out_if.ready = 1'b0;
        stall_seen   = 0;
        forever begin
            @(posedge i_clk);
            if (stall_req != stall_seen) begin
                stall_seen = stall_req;
                out_if.ready <= 1'b0;
                repeat (STALL_LEN) @(posedge i_clk);
            end
            out_if.ready <= ($urandom_range(99) >= idle_out);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL look_at_view_matrix");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            2: return $urandom_range(1) ? Q_MAX : Q_MIN;
            default: return $urandom_range(255) - 128;
        endcase
    endfunction

    task automatic send_request(input logic [DATA_W-1:0] ex, ey, ez, tx, ty, tz);
        // idle the sender cycle by cycle
        while ($urandom_range(99) < idle_in) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.eye_x    <= ex;
        in_if.eye_y    <= ey;
        in_if.eye_z    <= ez;
        in_if.target_x <= tx;
        in_if.target_y <= ty;
        in_if.target_z <= tz;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic write_up(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_requests(input int count, input int pause_at);
        logic [DATA_W-1:0] ex, ey, ez, tx, ty, tz;
        int                kind, mode;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) begin
                // hold the sender until the pipeline is empty
                drain();
            end
            kind = $urandom_range(99);
            mode = $urandom_range(3);
            ex = rand_coord(mode);
            ey = rand_coord(mode);
            ez = rand_coord(mode);
            tx = rand_coord($urandom_range(3));
            ty = rand_coord($urandom_range(3));
            tz = rand_coord($urandom_range(3));
            if (kind < 5) begin
                tx = ex; ty = ey; tz = ez;
            end else if (kind < 12) begin
                // look along the up axis of the default setup
                tx = ex; tz = ez;
            end else if (kind < 20) begin
                tx = ex + $urandom_range(2) - 1;
                ty = ey + $urandom_range(2) - 1;
                tz = ez + $urandom_range(2) - 1;
            end
            send_request(ex, ey, ez, tx, ty, tz);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_UP_X;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.eye_x  = '0;
        in_if.eye_y  = '0;
        in_if.eye_z  = '0;
        in_if.target_x = '0;
        in_if.target_y = '0;
        in_if.target_z = '0;
        stall_req    = 0;
        idle_in      = 38;
        idle_out     = 68;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default up vector
        send_request('0, '0, '0, '0, '0, '0);
        send_request(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        send_request(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_request(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
        send_request('0, 5 * Q_ONE, '0, '0, '0, '0);
        send_request('0, Q_MIN, '0, '0, Q_MAX, '0);
        send_request(Q_ONE, '0, '0, '0, '0, '0);
        send_request('0, '0, Q_ONE, '0, '0, '0);
        send_request('0, '0, 32'd1, '0, '0, '0);
        send_request(32'd1, 32'd1, 32'd1, '0, '0, '0);
        send_request(Q_MAX, Q_MAX, Q_MAX, Q_MAX - 1, Q_MAX, Q_MAX - 1);
        send_request(Q_MIN, Q_MIN, Q_MIN, Q_MIN + 1, Q_MIN + 7, Q_MIN);
        send_request(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN + 1, Q_MAX - 1);
        send_request(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, '0, '0, '0);
        send_request(32'h1234_5678, 32'hfedc_ba98, 32'h0f0f_0f0f, Q_MIN, Q_MAX, Q_ONE);
        random_requests(590, -1);
        drain();

        idle_in  = 68;
        idle_out = 38;
        write_up(REG_UP_X, Q_MAX);
        write_up(REG_UP_Y, Q_MIN);
        write_up(REG_UP_Z, Q_MAX);
        write_up(REG_SPARE, 32'hdead_beef);
        send_request('0, '0, '0, Q_MIN, Q_MAX, Q_MIN);
        send_request(Q_MIN, Q_MAX, Q_MIN, '0, '0, '0);
        random_requests(300, 150);
        drain();

        // zero up vector: right and upward axes collapse
        write_up(REG_UP_X, '0);
        write_up(REG_UP_Y, '0);
        write_up(REG_UP_Z, '0);
        random_requests(60, -1);
        drain();

        idle_in  = 0;
        idle_out = 0;
        write_up(REG_UP_X, $urandom);
        write_up(REG_UP_Y, $urandom);
        write_up(REG_UP_Z, $urandom);
        random_requests(300, -1);
        drain();

        write_up(REG_UP_X, 32'd1);
        write_up(REG_UP_Y, Q_MIN);
        write_up(REG_UP_Z, 32'hffff_ffff);
        stall_req = 1;
        random_requests(600, -1);
        drain();

        repeat (DRAIN_LEN) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("PASS look_at_view_matrix");
        else
            $display("FAIL look_at_view_matrix");
        $finish;
    end
endmodule
